>>> hdl/mbsp_pkg.sv
`default_nettype none

package mbsp_pkg;

  localparam int BUFFER_BYTES_DEF = 64;

  localparam logic [1:0] KIND_CHANNEL  = 2'd0;
  localparam logic [1:0] KIND_SYSEX    = 2'd1;
  localparam logic [1:0] KIND_REALTIME = 2'd2;

  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;
  localparam logic [7:0] RT_CLOCK    = 8'hF8;
  localparam logic [7:0] RT_START    = 8'hFA;
  localparam logic [7:0] RT_CONTINUE = 8'hFB;
  localparam logic [7:0] RT_STOP     = 8'hFC;
  localparam logic [7:0] RT_RESET    = 8'hFF;

  localparam logic [3:0] HI_PROG     = 4'hC;
  localparam logic [3:0] HI_PRESSURE = 4'hD;
  localparam logic [3:0] HI_SYSTEM   = 4'hF;

endpackage

`default_nettype wire

>>> hdl/midi_byte_stream_parser.sv
`default_nettype none

// channel   direction  handshake                 payload
// in        sink       in_valid_i / in_ready_o   in_byte_i
// out       source     out_valid_o / out_ready_i kind_o .. truncated_o
// cfg       sink       cfg_we_i                  cfg_wdata_i (midi_enabled)
//
// One byte per cycle is taken while the sysex buffer is idle and the output register is free or drains.
// An F7 closing a sysex run blocks input while the buffer sends out its stored bytes:
// each byte is one read of the buffer memory, then one load that waits for the output slot.
// Reset is asynchronous, active low; the sysex buffer needs no clearing.
// Output stalls hold input ready low only when the output register is full.

module midi_byte_stream_parser #(
  parameter int BUFFER_BYTES = mbsp_pkg::BUFFER_BYTES_DEF,
  localparam int ADDR_W = $clog2(BUFFER_BYTES),
  localparam int FILL_W = $clog2(BUFFER_BYTES + 1)
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      status_o,
  output logic [6:0]      data1_o,
  output logic [6:0]      data2_o,
  output logic [1:0]      msg_len_o,
  output logic [7:0]      sysex_value_o,
  output logic            last_o,
  output logic            truncated_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RECV = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;

  localparam logic [1:0] OPEN_NONE  = 2'd0;
  localparam logic [1:0] OPEN_SYSEX = 2'd1;
  localparam logic [1:0] OPEN_MIDI  = 2'd2;

  localparam logic [FILL_W-1:0] LIM = FILL_W'(BUFFER_BYTES);

  logic              enabled_q;
  logic [1:0]        phase_q, phase_d;
  logic [1:0]        open_q, open_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [1:0]        exp_q, exp_d;
  logic [7:0]        rs_q, rs_d;
  logic              ovf_q, ovf_d;
  logic [7:0]        chan_st_q, chan_st_d;
  logic [6:0]        data1_q, data1_d;

  logic              acc;
  logic              emit;
  logic [1:0]        e_kind;
  logic [7:0]        e_status;
  logic [6:0]        e_d1;
  logic [6:0]        e_d2;
  logic [1:0]        e_len;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [7:0]        wd;
  logic              drain;
  logic [ADDR_W-1:0] drain_last;

  logic              sx_busy;
  logic              sx_valid;
  logic [7:0]        sx_byte;
  logic              sx_last;
  logic              slot_free;

  logic              out_valid_q;
  logic [1:0]        kind_q;
  logic [7:0]        status_q;
  logic [6:0]        od1_q;
  logic [6:0]        od2_q;
  logic [1:0]        len_q;
  logic [7:0]        sxv_q;
  logic              last_q;
  logic              trunc_q;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = !sx_busy && slot_free;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    logic [1:0]        ph;
    logic [1:0]        ok;
    logic [FILL_W-1:0] fl;
    logic [FILL_W-1:0] fl_inc;
    logic [1:0]        ex;
    logic [7:0]        b;

    b         = in_byte_i;
    phase_d   = phase_q;
    open_d    = open_q;
    fill_d    = fill_q;
    exp_d     = exp_q;
    rs_d      = rs_q;
    ovf_d     = ovf_q;
    chan_st_d = chan_st_q;
    data1_d   = data1_q;
    emit      = 1'b0;
    e_kind    = mbsp_pkg::KIND_REALTIME;
    e_status  = b;
    e_d1      = '0;
    e_d2      = '0;
    e_len     = mbsp_pkg::LEN_ONE;
    we        = 1'b0;
    wa        = fill_q[ADDR_W-1:0];
    wd        = b;
    drain     = 1'b0;
    drain_last = fill_q[ADDR_W-1:0];
    ph        = phase_q;
    ok        = open_q;
    fl        = fill_q;
    ex        = exp_q;
    fl_inc    = fill_q + FILL_W'(1);

    if (acc) begin
      if (b >= mbsp_pkg::RT_CLOCK) begin
        rs_d = '0;
        if (b inside {mbsp_pkg::RT_CLOCK, mbsp_pkg::RT_START, mbsp_pkg::RT_CONTINUE,
                      mbsp_pkg::RT_STOP, mbsp_pkg::RT_RESET}) begin
          emit = 1'b1;
        end
      end else if (b[7]) begin
        if (b == mbsp_pkg::SYSEX_START) begin
          rs_d = '0;
          if (open_q == OPEN_NONE) begin
            open_d  = OPEN_SYSEX;
            phase_d = PH_RECV;
            we      = 1'b1;
            wa      = '0;
            fill_d  = FILL_W'(1);
            ovf_d   = 1'b0;
          end
        end else if (b == mbsp_pkg::SYSEX_END) begin
          rs_d = '0;
          if (open_q == OPEN_SYSEX) begin
            drain = 1'b1;
            if (fill_q < LIM) begin
              we         = 1'b1;
              fill_d     = fl_inc;
              drain_last = fill_q[ADDR_W-1:0];
            end else begin
              ovf_d      = 1'b1;
              fl_inc     = fill_q - FILL_W'(1);
              drain_last = fl_inc[ADDR_W-1:0];
            end
            open_d  = OPEN_NONE;
            phase_d = PH_IDLE;
          end
        end else if (b[7:4] == mbsp_pkg::HI_SYSTEM) begin
          rs_d = '0;
        end else begin
          if (b[7:4] == mbsp_pkg::HI_PROG || b[7:4] == mbsp_pkg::HI_PRESSURE) begin
            exp_d = mbsp_pkg::LEN_TWO;
          end else begin
            exp_d = mbsp_pkg::LEN_THREE;
            rs_d  = b;
          end
          if (open_q == OPEN_NONE) begin
            open_d    = OPEN_MIDI;
            phase_d   = PH_RECV;
            chan_st_d = b;
            fill_d    = FILL_W'(1);
          end
        end
      end else begin
        if (phase_q == PH_IDLE && rs_q != '0) begin
          ph        = PH_RECV;
          ok        = OPEN_MIDI;
          fl        = FILL_W'(1);
          ex        = mbsp_pkg::LEN_THREE;
          exp_d     = mbsp_pkg::LEN_THREE;
          chan_st_d = rs_q;
          phase_d   = PH_RECV;
          open_d    = OPEN_MIDI;
          fill_d    = FILL_W'(1);
        end
        fl_inc = fl + FILL_W'(1);
        if (ph == PH_RECV) begin
          if (fl < LIM) begin
            if (ok == OPEN_MIDI) begin
              if (fl_inc >= FILL_W'(ex)) begin
                emit     = enabled_q;
                e_kind   = mbsp_pkg::KIND_CHANNEL;
                e_status = chan_st_d;
                if (fl == FILL_W'(1)) begin
                  e_d1  = b[6:0];
                  e_len = mbsp_pkg::LEN_TWO;
                end else begin
                  e_d1  = data1_q;
                  e_d2  = b[6:0];
                  e_len = mbsp_pkg::LEN_THREE;
                end
                fill_d  = '0;
                phase_d = PH_IDLE;
                open_d  = OPEN_NONE;
              end else begin
                data1_d = b[6:0];
                fill_d  = fl_inc;
              end
            end else begin
              we     = 1'b1;
              wa     = fl[ADDR_W-1:0];
              fill_d = fl_inc;
            end
          end else begin
            phase_d = PH_WAIT;
            ovf_d   = 1'b1;
          end
        end else if (ph == PH_WAIT) begin
          ovf_d = 1'b1;
        end
      end
    end
  end

  mbsp_sysex_buf #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_sysex_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (we),
    .wr_addr_i    (wa),
    .wr_data_i    (wd),
    .start_i      (drain),
    .last_idx_i   (drain_last),
    .busy_o       (sx_busy),
    .byte_valid_o (sx_valid),
    .byte_o       (sx_byte),
    .byte_last_o  (sx_last),
    .byte_ready_i (slot_free)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b1;
      phase_q     <= PH_IDLE;
      open_q      <= OPEN_NONE;
      fill_q      <= '0;
      exp_q       <= mbsp_pkg::LEN_THREE;
      rs_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enabled_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      open_q  <= open_d;
      fill_q  <= fill_d;
      exp_q   <= exp_d;
      rs_q    <= rs_d;
      ovf_q   <= ovf_d;
      if (emit || (sx_valid && slot_free)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chan_st_q <= chan_st_d;
    data1_q   <= data1_d;
    if (emit) begin
      kind_q   <= e_kind;
      status_q <= e_status;
      od1_q    <= e_d1;
      od2_q    <= e_d2;
      len_q    <= e_len;
      sxv_q    <= '0;
      last_q   <= 1'b0;
      trunc_q  <= 1'b0;
    end else if (sx_valid && slot_free) begin
      kind_q   <= mbsp_pkg::KIND_SYSEX;
      status_q <= '0;
      od1_q    <= '0;
      od2_q    <= '0;
      len_q    <= mbsp_pkg::LEN_ONE;
      sxv_q    <= sx_byte;
      last_q   <= sx_last;
      trunc_q  <= ovf_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign status_o      = status_q;
  assign data1_o       = od1_q;
  assign data2_o       = od2_q;
  assign msg_len_o     = len_q;
  assign sysex_value_o = sxv_q;
  assign last_o        = last_q;
  assign truncated_o   = trunc_q;

endmodule

`default_nettype wire

>>> hdl/mbsp_sysex_buf.sv
`default_nettype none

module mbsp_sysex_buf #(
  parameter int BUFFER_BYTES = mbsp_pkg::BUFFER_BYTES_DEF,
  localparam int ADDR_W = $clog2(BUFFER_BYTES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [7:0]        wr_data_i,
  input  wire logic              start_i,
  input  wire logic [ADDR_W-1:0] last_idx_i,
  output logic                   busy_o,
  output logic                   byte_valid_o,
  output logic [7:0]             byte_o,
  output logic                   byte_last_o,
  input  wire logic              byte_ready_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [7:0]        mem [BUFFER_BYTES];
  logic [7:0]        rd_data_q;
  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] rd_idx_q, rd_idx_d;
  logic [ADDR_W-1:0] last_idx_q, last_idx_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_idx_q];
  end

  always_comb begin
    state_d    = state_q;
    rd_idx_d   = rd_idx_q;
    last_idx_d = last_idx_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          rd_idx_d   = '0;
          last_idx_d = last_idx_i;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (byte_ready_i) begin
          if (rd_idx_q == last_idx_q) begin
            state_d = ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + ADDR_W'(1);
            state_d  = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_idx_q   <= '0;
      last_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      rd_idx_q   <= rd_idx_d;
      last_idx_q <= last_idx_d;
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign byte_valid_o = (state_q == ST_LOAD);
  assign byte_o       = rd_data_q;
  assign byte_last_o  = (rd_idx_q == last_idx_q);

endmodule

`default_nettype wire
